[src/pcv_pkg.sv]
// Package for the path component validator: payload types, codes, path state
// and the per-byte segment update functions. No dependencies.
`default_nettype none

package pcv_pkg;

   localparam int unsigned KEPT_W   = 13;
   localparam int unsigned STRIP_W  = 16;
   localparam int unsigned DATA_W   = 32;
   localparam int unsigned ADDR_W   = 3;

   localparam logic [KEPT_W-1:0]  KEPT_MAX     = KEPT_W'(4096);
   localparam logic [STRIP_W-1:0] STRIP_MAX    = STRIP_W'(65535);
   localparam logic [KEPT_W-1:0]  PATH_LIMIT   = KEPT_W'(256);
   localparam logic [KEPT_W-1:0]  CAPACITY_RST = KEPT_W'(4096);

   localparam logic [7:0] CHAR_BSLASH = 8'h5C;
   localparam logic [7:0] CHAR_SLASH  = 8'h2F;
   localparam logic [7:0] CHAR_DOT    = 8'h2E;

   // register index (paddr[2])
   localparam logic REG_WRITE_RULE      = 1'b0;
   localparam logic REG_BUFFER_CAPACITY = 1'b1;

   typedef enum logic [2:0] {
      FAULT_OK        = 3'd0,
      FAULT_BACKSLASH = 3'd1,
      FAULT_EMPTY     = 3'd2,
      FAULT_TOO_LONG  = 3'd3,
      FAULT_EMPTY_SEG = 3'd4,
      FAULT_DOT       = 3'd5,
      FAULT_DOTDOT    = 3'd6,
      FAULT_HIDDEN    = 3'd7
   } fault_type;

   typedef enum logic [1:0] {
      PH_STRIP = 2'd0,
      PH_DOT   = 2'd1,
      PH_KEEP  = 2'd2
   } phase_type;

   typedef struct packed {
      logic [7:0] path_byte;
      logic       final_byte;
   } req_payload_type;

   typedef struct packed {
      logic              accepted;
      logic [2:0]        fault_code;
      logic [STRIP_W-1:0] strip_count;
      logic [KEPT_W-1:0]  kept_length;
   } rsp_payload_type;

   // segment tracking for the kept part
   typedef struct packed {
      logic [1:0]        seg_len;
      logic [1:0]        dot_marks;
      logic [KEPT_W-1:0] kept;
      fault_type         seg_fault;
   } seg_state_type;

   typedef struct packed {
      phase_type          phase;
      seg_state_type      seg;
      logic [STRIP_W-1:0] stripped;
      logic               backslash;
   } path_state_type;

   localparam path_state_type PATH_RST = '{
      phase:     PH_STRIP,
      seg:       '{seg_len: 2'd0, dot_marks: 2'd0, kept: '0, seg_fault: FAULT_OK},
      stripped:  '0,
      backslash: 1'b0
   };

   // first segment fault wins, but replaces a pending hidden mark
   function automatic seg_state_type note_fault(seg_state_type s, fault_type code);
      seg_state_type r;
      r = s;
      if (s.seg_fault == FAULT_OK || s.seg_fault == FAULT_HIDDEN) r.seg_fault = code;
      return r;
   endfunction

   function automatic seg_state_type close_segment(seg_state_type s);
      seg_state_type r;
      r = s;
      if (s.seg_len == 2'd0)
         r = note_fault(r, FAULT_EMPTY_SEG);
      else if (s.seg_len == 2'd1 && s.dot_marks[0])
         r = note_fault(r, FAULT_DOT);
      else if (s.seg_len == 2'd2 && s.dot_marks == 2'b11)
         r = note_fault(r, FAULT_DOTDOT);
      r.seg_len   = 2'd0;
      r.dot_marks = 2'd0;
      return r;
   endfunction

   function automatic seg_state_type keep_byte(seg_state_type s, logic [7:0] c);
      seg_state_type r;
      r = s;
      if (s.kept < KEPT_MAX) r.kept = s.kept + KEPT_W'(1);
      if (c == CHAR_SLASH) begin
         r = close_segment(r);
      end else begin
         if (c == CHAR_DOT) begin
            if (s.seg_len == 2'd0) begin
               r.dot_marks[0] = 1'b1;
               if (s.seg_fault == FAULT_OK) r.seg_fault = FAULT_HIDDEN;
            end else if (s.seg_len == 2'd1) begin
               r.dot_marks[1] = 1'b1;
            end
         end
         if (s.seg_len != 2'd3) r.seg_len = s.seg_len + 2'd1;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

[src/pcv_byte_step.sv]
// Combinational per-byte update of the path state and the verdict for a
// final byte. Depends on pcv_pkg.
`default_nettype none

module pcv_byte_step (
   input  pcv_pkg::path_state_type               cur_state,
   input  logic [7:0]                            path_byte,
   input  logic                                  final_byte,
   input  logic                                  write_rule,
   input  logic [pcv_pkg::KEPT_W-1:0]            buffer_capacity,
   output pcv_pkg::path_state_type               next_state,
   output pcv_pkg::rsp_payload_type              verdict
);
   import pcv_pkg::*;

   path_state_type        st;
   seg_state_type         fin;
   logic [STRIP_W:0]      strip_sum;
   logic [1:0]            strip_add;
   fault_type             code;

   always_comb begin
      st        = cur_state;
      strip_add = 2'd0;
      if (path_byte == CHAR_BSLASH) st.backslash = 1'b1;
      unique case (cur_state.phase)
         PH_STRIP: begin
            if (path_byte == CHAR_SLASH) begin
               strip_add = 2'd1;
            end else if (path_byte == CHAR_DOT) begin
               st.phase = PH_DOT;
            end else begin
               st.phase = PH_KEEP;
               st.seg   = keep_byte(cur_state.seg, path_byte);
            end
         end
         PH_DOT: begin
            if (path_byte == CHAR_SLASH) begin
               strip_add = 2'd2;
               st.phase  = PH_STRIP;
            end else begin
               st.phase = PH_KEEP;
               st.seg   = keep_byte(keep_byte(cur_state.seg, CHAR_DOT), path_byte);
            end
         end
         default: begin
            st.seg = keep_byte(cur_state.seg, path_byte);
         end
      endcase
      strip_sum = {1'b0, cur_state.stripped} + (STRIP_W+1)'(strip_add);
      st.stripped = (strip_sum > {1'b0, STRIP_MAX}) ? STRIP_MAX : strip_sum[STRIP_W-1:0];
   end

   assign next_state = st;

   // end of path: a pending lone dot is kept, then the open segment closes
   always_comb begin
      fin = st.seg;
      if (st.phase == PH_DOT) fin = keep_byte(fin, CHAR_DOT);
      if (fin.kept != '0 && path_byte != CHAR_SLASH) fin = close_segment(fin);

      priority if (st.backslash)
         code = FAULT_BACKSLASH;
      else if (fin.kept == '0)
         code = FAULT_EMPTY;
      else if (fin.kept >= buffer_capacity || fin.kept >= PATH_LIMIT)
         code = FAULT_TOO_LONG;
      else if (fin.seg_fault == FAULT_EMPTY_SEG || fin.seg_fault == FAULT_DOT
               || fin.seg_fault == FAULT_DOTDOT)
         code = fin.seg_fault;
      else if (fin.seg_fault == FAULT_HIDDEN && write_rule)
         code = FAULT_HIDDEN;
      else
         code = FAULT_OK;

      verdict.accepted    = (code == FAULT_OK) && final_byte;
      verdict.fault_code  = code;
      verdict.strip_count = st.stripped;
      verdict.kept_length = fin.kept;
   end

endmodule

`default_nettype wire

[src/path_component_validator_top.sv]
// Path component validator, top level: handshakes, register file, path state.
// Depends on pcv_pkg and pcv_byte_step.
// Throughput: one path byte per cycle; a final byte waits only while a verdict is held.
// Output: the verdict is registered; once its final byte leaves the input register, the
//   verdict sits in the result register with rsp_valid high.
// Reset: synchronous, active high; clears path state and valid flags, write_rule 0, capacity 4096.
`default_nettype none

module path_component_validator_top (
   input  logic                           clock,
   input  logic                           reset,
   // request channel: one path byte per request
   input  logic                           req_valid,
   output logic                           req_stall,
   input  pcv_pkg::req_payload_type       req_payload,
   // response channel: one verdict per path
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output pcv_pkg::rsp_payload_type       rsp_payload,
   // register port
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [pcv_pkg::ADDR_W-1:0]     paddr,
   input  logic [pcv_pkg::DATA_W-1:0]     pwdata,
   output logic [pcv_pkg::DATA_W-1:0]     prdata,
   output logic                           pready
);
   import pcv_pkg::*;

   // configuration registers
   logic                 write_rule_ff;
   logic [KEPT_W-1:0]    capacity_ff;
   logic                 cfg_write;

   // input register stage
   logic                 in_valid_ff,  in_valid_in;
   req_payload_type      in_payload_ff;

   // running path state, owned by the byte in the input register once it moves
   path_state_type       path_ff,      path_in;
   path_state_type       step_state;
   rsp_payload_type      step_verdict;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_payload_type      rsp_payload_ff;

   logic                 rsp_free;     // result register can take a verdict
   logic                 stage_move;   // input-register byte is consumed this cycle
   logic                 req_take;

   //--------------------------------------------------------------------------
   // Register port: writes land on the access phase, pready tied high.
   //--------------------------------------------------------------------------
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite;

   always_comb begin
      unique case (paddr[2])
         REG_WRITE_RULE:      prdata = {{(DATA_W-1){1'b0}}, write_rule_ff};
         REG_BUFFER_CAPACITY: prdata = {{(DATA_W-KEPT_W){1'b0}}, capacity_ff};
         default:             prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         write_rule_ff <= 1'b0;
         capacity_ff   <= CAPACITY_RST;
      end else if (cfg_write) begin
         if (paddr[2] == REG_WRITE_RULE) write_rule_ff <= pwdata[0];
         else                            capacity_ff   <= pwdata[KEPT_W-1:0];
      end
   end

   //--------------------------------------------------------------------------
   // Flow control. A non-final byte always moves on; a final byte needs the
   // result register empty or draining this cycle. The input register stalls
   // only behind a final byte that cannot move.
   //--------------------------------------------------------------------------
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign stage_move = in_valid_ff && (!in_payload_ff.final_byte || rsp_free);
   assign req_stall  = in_valid_ff && !stage_move;
   assign req_take   = req_valid && !req_stall;

   assign in_valid_in = req_stall ? in_valid_ff : req_valid;

   //--------------------------------------------------------------------------
   // Per-byte update
   //--------------------------------------------------------------------------
   pcv_byte_step u_step (
      .cur_state       (path_ff),
      .path_byte       (in_payload_ff.path_byte),
      .final_byte      (in_payload_ff.final_byte),
      .write_rule      (write_rule_ff),
      .buffer_capacity (capacity_ff),
      .next_state      (step_state),
      .verdict         (step_verdict)
   );

   // the final byte starts the next path from a clean state
   always_comb begin
      path_in = path_ff;
      if (stage_move) path_in = in_payload_ff.final_byte ? PATH_RST : step_state;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (stage_move && in_payload_ff.final_byte) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         path_ff      <= PATH_RST;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         path_ff      <= path_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_take) in_payload_ff <= req_payload;
      if (stage_move && in_payload_ff.final_byte) rsp_payload_ff <= step_verdict;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

`default_nettype wire

[src/pcv_checker.sv]
// Port-level checker for the path component validator, bound to the top level.
// Depends on pcv_pkg and path_component_validator_top.
`default_nettype none

module pcv_checker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_stall,
   input  logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  pcv_pkg::rsp_payload_type  rsp_payload
);
   import pcv_pkg::*;

   // a stalled verdict holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response changed");

   a_ok_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.accepted == (rsp_payload.fault_code == FAULT_OK))
      else $error("accepted flag disagrees with fault code");

   a_ok_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.accepted |->
         rsp_payload.kept_length != '0 && rsp_payload.kept_length < PATH_LIMIT)
      else $error("accepted path with bad kept length");

   a_empty_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.fault_code == FAULT_EMPTY |->
         rsp_payload.kept_length == '0)
      else $error("empty fault with nonzero kept length");

   // both channels come out of reset idle
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("response valid or request stall after reset");

endmodule

bind path_component_validator_top pcv_checker u_pcv_checker (.*);

`default_nettype wire
